// ===== hw/rtl/htls_pkg.sv =====
// Package for the HTTP token search block: shared widths, register indexes
// and the input beat type. No dependencies.
package htls_pkg;

  // Widths fixed by the register map and the beat fields.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned BYTE_W     = 8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TOKEN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOKEN_WORD0  = 3'd1;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              byte_present;
    logic              end_of_text;
  } htls_beat_t;

endpackage

// ===== hw/rtl/htls_cfg_regs.sv =====
// Configuration registers of the token search: token length and token bytes.
// Depends on htls_pkg.
module htls_cfg_regs import htls_pkg::*; #(
  parameter int unsigned MAX_TOKEN_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  output logic [LEN_W-1:0]              token_len,
  output logic [MAX_TOKEN_BYTES*8-1:0]  token_bytes
);

  logic [LEN_W-1:0]             len_r;
  logic [MAX_TOKEN_BYTES*8-1:0] bytes_r;

  // Each stored byte belongs to one 64-bit word register; bytes beyond
  // the stored depth are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_W'(1);
      bytes_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_TOKEN_LENGTH) begin
        len_r <= cfg_wdata[LEN_W-1:0];
      end
      for (int j = 0; j < int'(MAX_TOKEN_BYTES); j++) begin
        if (cfg_index == REG_TOKEN_WORD0 + CFG_IDX_W'(j / 8)) begin
          bytes_r[j*8 +: 8] <= cfg_wdata[(j % 8)*8 +: 8];
        end
      end
    end
  end

  assign token_len   = len_r;
  assign token_bytes = bytes_r;

endmodule

// ===== hw/rtl/htls_match.sv =====
// Per-byte match core: classes the byte, steps the run state and forms the
// found flag for a beat that ends the string. Depends on htls_pkg.
module htls_match import htls_pkg::*; #(
  parameter int unsigned MAX_TOKEN_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  htls_beat_t                    beat,
  input  logic [LEN_W-1:0]              token_len,
  input  logic [MAX_TOKEN_BYTES*8-1:0]  token_bytes,
  output logic                          found
);

  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic             alive_r, alive_nxt;
  logic             prev_r, prev_nxt;
  logic             hit_r, hit_nxt;

  logic [LEN_W-1:0] pos_s, pos1;
  logic             alive_s, alive1, prev1, hit1;
  logic             is_tc, len_ok, cmp_ok;
  logic [7:0]       low, tok_byte, b;

  // RFC 2616 token character class.
  always_comb begin
    b = beat.text_byte;
    is_tc = 1'b1;
    if (b <= 8'd32 || b >= 8'd127) begin
      is_tc = 1'b0;
    end
    if (b == "(" || b == ")" || b == "<" || b == ">" || b == "@" || b == "," ||
        b == ";" || b == ":" || b == "\\" || b == "\"" || b == "/" || b == "[" ||
        b == "]" || b == "?" || b == "=" || b == "{" || b == "}") begin
      is_tc = 1'b0;
    end
    low = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  end

  assign len_ok  = (token_len >= LEN_W'(1)) && (token_len <= LEN_W'(MAX_TOKEN_BYTES));
  // A new run restarts the compare at position zero.
  assign pos_s   = prev_r ? pos_r : '0;
  assign alive_s = prev_r ? alive_r : 1'b1;

  // Select the token byte at the current position.
  always_comb begin
    tok_byte = '0;
    for (int j = 0; j < int'(MAX_TOKEN_BYTES); j++) begin
      if (pos_s == LEN_W'(j)) begin
        tok_byte = token_bytes[j*8 +: 8];
      end
    end
  end

  assign cmp_ok = len_ok && (pos_s < token_len) && (low == tok_byte);

  // State after the byte, then the end-of-string close and clear.
  always_comb begin
    pos1   = pos_r;
    alive1 = alive_r;
    prev1  = prev_r;
    hit1   = hit_r;
    if (beat.byte_present) begin
      if (is_tc) begin
        pos1   = (alive_s && cmp_ok) ? pos_s + LEN_W'(1) : pos_s;
        alive1 = alive_s && cmp_ok;
        prev1  = 1'b1;
      end else begin
        hit1   = hit_r | (prev_r && alive_r && len_ok && pos_r == token_len);
        alive1 = 1'b0;
        prev1  = 1'b0;
      end
    end
    found = hit1 | (prev1 && alive1 && len_ok && pos1 == token_len);
    if (beat.end_of_text) begin
      pos_nxt   = '0;
      alive_nxt = 1'b0;
      prev_nxt  = 1'b0;
      hit_nxt   = 1'b0;
    end else begin
      pos_nxt   = pos1;
      alive_nxt = alive1;
      prev_nxt  = prev1;
      hit_nxt   = hit1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      alive_r <= 1'b0;
      prev_r  <= 1'b0;
      hit_r   <= 1'b0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      alive_r <= alive_nxt;
      prev_r  <= prev_nxt;
      hit_r   <= hit_nxt;
    end
  end

endmodule

// ===== hw/rtl/http_token_list_search.sv =====
// The result of the beat that ends the string passes through the input register,
// then the result register, before it is offered at the output.
// Throughput: one byte per cycle unless the result side stalls; one run step per byte.
// Reset (rst_n low, synchronous): token length 1, token bytes 0, run state
// cleared, both pipeline registers empty.
module http_token_list_search import htls_pkg::*; #(
  parameter int unsigned MAX_TOKEN_BYTES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] text_byte
  input  logic                  in_tuser,   // [0] byte_present
  input  logic                  in_tlast,   // end_of_text
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [0] token_found, [7:1] zero
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [LEN_W-1:0]             token_len;
  logic [MAX_TOKEN_BYTES*8-1:0] token_bytes;
  htls_beat_t                   beat_r;
  logic                         beat_v_r;
  logic                         out_v_r;
  logic                         found_r;
  logic                         found;
  logic                         advance;

  htls_cfg_regs #(.MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .token_len  (token_len),
    .token_bytes(token_bytes)
  );

  // The pipeline moves whenever the result register is free or being drained.
  assign advance   = !out_v_r || out_tready;
  assign in_tready = !beat_v_r || advance;

  htls_match #(.MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)) u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (beat_v_r && advance),
    .beat       (beat_r),
    .token_len  (token_len),
    .token_bytes(token_bytes),
    .found      (found)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_v_r <= 1'b0;
    end else if (in_tready) begin
      beat_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      beat_r.text_byte    <= in_tdata;
      beat_r.byte_present <= in_tuser;
      beat_r.end_of_text  <= in_tlast;
    end
  end

  // Result register: loaded by the beat that ends the string.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= beat_v_r && beat_r.end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && beat_v_r && beat_r.end_of_text) begin
      found_r <= found;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, found_r};

endmodule

// ===== hw/rtl/htls_checker.sv =====
// Port-level checks for http_token_list_search, attached by bind.
// Depends on htls_pkg.
module htls_checker import htls_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Only the found bit may be set.
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'd0)
    else $error("result padding not zero");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // With no result pending, the input side never stalls.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with free result register");

endmodule

bind http_token_list_search htls_checker u_htls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// ===== tb/http_token_list_search_tb.sv =====
// Testbench for http_token_list_search: drives header values as byte beats and
// checks each found flag against a built-in whole-token predictor.
// Depends on htls_pkg and the http_token_list_search RTL only.
module http_token_list_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htls_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int PHASE_ITEMS  = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_TOKEN    = 32;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [7:0] text_byte
  logic                  in_tuser = 1'b0; // [0] byte_present
  logic                  in_tlast = 1'b0; // end_of_text
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;       // [0] token_found, [7:1] zero
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  http_token_list_search #(.MAX_TOKEN_BYTES(MAX_TOKEN)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Directed stimulus rows: either one input beat or one register write.
  typedef enum bit {ROW_BEAT, ROW_WRITE} row_kind_t;
  typedef struct {
    row_kind_t            kind;
    logic [7:0]           text_byte;
    bit                   present;
    bit                   last;
    bit                   typed;
    bit                   typed_found;
    logic [CFG_IDX_W-1:0] idx;
    logic [63:0]          data;
  } dir_row_t;

  // Shadow copy of the registers and the scan state of the block.
  logic [5:0]  tok_len = 6'd1;
  logic [63:0] tok_word [4] = '{default: '0};
  logic [5:0]  run_pos = '0;
  bit          run_live = 1'b0;
  bit          in_run = 1'b0;
  bit          hit_in_text = 1'b0;

  bit         found_expected_q [$];
  logic [7:0] value_bytes [$];
  int         fail_count = 0;
  int         items_sent = 0;
  bit         gaps_on = 1'b1;
  int         hold_asks = 0;
  int         hold_served = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic bit is_tok_char(input logic [7:0] c);
    if (c <= 8'd32 || c >= 8'd127) return 1'b0;
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=",
      "{", "}": return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic logic [7:0] stored_byte(input logic [5:0] pos);
    return tok_word[pos[4:3]][pos[2:0]*8 +: 8];
  endfunction

  function automatic bit len_valid();
    return tok_len >= 6'd1 && tok_len <= 6'(MAX_TOKEN);
  endfunction

  // A run of token characters ends: it is a hit if it spelled the whole token.
  function automatic void close_token_run();
    if (in_run && run_live && len_valid() && run_pos == tok_len) hit_in_text = 1'b1;
    run_live = 1'b0;
    in_run = 1'b0;
  endfunction

  // Advances the scan state by one beat; returns 1 when the beat ends the text.
  function automatic bit predict_found(input logic [7:0] c, input bit present,
                                       input bit last, output bit found);
    logic [7:0] low;
    found = 1'b0;
    if (present) begin
      if (is_tok_char(c)) begin
        low = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (!in_run) begin
          run_pos = '0;
          run_live = 1'b1;
        end
        if (run_live) begin
          if (len_valid() && run_pos < tok_len && low == stored_byte(run_pos))
            run_pos = run_pos + 6'd1;
          else
            run_live = 1'b0;
        end
        in_run = 1'b1;
      end else begin
        close_token_run();
      end
    end
    if (!last) return 1'b0;
    close_token_run();
    found = hit_in_text;
    run_pos = '0;
    run_live = 1'b0;
    in_run = 1'b0;
    hit_in_text = 1'b0;
    return 1'b1;
  endfunction

  function automatic void flag_error(input string what);
    fail_count++;
    if (fail_count <= 10) $display("ERROR at %0t ns: %s", $time, what);
  endfunction

  function automatic logic [7:0] rand_token_char();
    string tchars;
    tchars = "abcdefghijklmnopqrstuvwxyz0123456789!#$%&'*+-.^_`|~";
    return tchars[$urandom_range(tchars.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_separator();
    logic [7:0] c;
    case ($urandom_range(5))
      0: c = ",";
      1: c = " ";
      2: c = ";";
      3: c = 8'h09;
      4: c = "=";
      default: begin
        c = 8'($urandom_range(255));
        while (is_tok_char(c)) c = 8'($urandom_range(255));
      end
    endcase
    return c;
  endfunction

  // Appends the first n stored token bytes, letters in random case.
  function automatic void append_token(input int n);
    logic [7:0] c;
    for (int j = 0; j < n; j++) begin
      c = stored_byte(6'(j));
      if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
      value_bytes.push_back(c);
    end
  endfunction

  function automatic dir_row_t b_row(input logic [7:0] c, input bit p, input bit l);
    dir_row_t r;
    r = '{kind: ROW_BEAT, text_byte: c, present: p, last: l, typed: 1'b0,
          typed_found: 1'b0, idx: '0, data: '0};
    return r;
  endfunction

  function automatic dir_row_t b_row_exp(input logic [7:0] c, input bit p, input bit l,
                                         input bit found);
    dir_row_t r;
    r = b_row(c, p, l);
    r.typed = 1'b1;
    r.typed_found = found;
    return r;
  endfunction

  function automatic dir_row_t c_row(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
    dir_row_t r;
    r = b_row(8'h00, 1'b0, 1'b0);
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = d;
    return r;
  endfunction

  // Offers one beat, waits for the handshake and records the expected flag.
  task automatic send_beat(input logic [7:0] c, input bit present, input bit last,
                           input bit typed = 1'b0, input bit typed_found = 1'b0);
    bit done;
    bit found;
    while (gaps_on && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= present;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    done = predict_found(c, present, last, found);
    if (done) found_expected_q.push_back(typed ? typed_found : found);
    items_sent++;
  endtask

  // Stops offering beats and waits until the block has nothing left in flight.
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (found_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_TOKEN_LENGTH) tok_len = d[5:0];
    else tok_word[2'(idx - REG_TOKEN_WORD0)] = d;
  endtask

  // Picks a token for one phase; the first phases take the length extremes.
  task automatic load_token(input int phase);
    logic [5:0]  len;
    logic [63:0] data;
    int          pos;
    settle_idle();
    case (phase)
      0: len = 6'd32;
      1: len = 6'd0;
      2: len = 6'($urandom_range(33, 63));
      default: begin
        case ($urandom_range(4))
          0: len = 6'd32;
          1: len = 6'd1;
          default: len = 6'($urandom_range(2, 8));
        endcase
      end
    endcase
    data = {$urandom(), $urandom()};
    data[5:0] = len;
    write_reg(REG_TOKEN_LENGTH, data);
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 8; j++) data[j*8 +: 8] = rand_token_char();
      // Now and then a stored byte is one that no lowercased run byte can equal.
      if (k == 0 && $urandom_range(5) == 0) begin
        pos = $urandom_range(7);
        case ($urandom_range(2))
          0: data[pos*8 +: 8] = 8'("A" + $urandom_range(25));
          1: data[pos*8 +: 8] = 8'hff;
          default: data[pos*8 +: 8] = ",";
        endcase
      end
      write_reg(CFG_IDX_W'(REG_TOKEN_WORD0 + k), data);
    end
  endtask

  // Builds one header value as a list of elements, mostly near the token, and sends it.
  task automatic send_random_value();
    int n_elem;
    int elen;
    bit end_on_byte;
    value_bytes.delete();
    elen = len_valid() ? int'(tok_len) : (tok_len == 6'd0 ? 3 : MAX_TOKEN);
    n_elem = $urandom_range(0, 4);
    if ($urandom_range(3) == 0) value_bytes.push_back(rand_separator());
    for (int k = 0; k < n_elem; k++) begin
      if (k > 0) repeat ($urandom_range(1, 2)) value_bytes.push_back(rand_separator());
      case ($urandom_range(9))
        0, 1, 2, 3: append_token(elen);
        4: append_token(elen > 1 ? elen - 1 : elen);
        5: begin
          append_token(elen);
          value_bytes.push_back(rand_token_char());
        end
        6: begin
          value_bytes.push_back(rand_token_char());
          append_token(elen);
        end
        7: repeat ($urandom_range(1, 6)) value_bytes.push_back(rand_token_char());
        default: repeat ($urandom_range(1, 4)) value_bytes.push_back(8'($urandom_range(255)));
      endcase
    end
    if ($urandom_range(4) == 0) value_bytes.push_back(rand_separator());
    end_on_byte = value_bytes.size() > 0 && $urandom_range(1);
    foreach (value_bytes[j]) begin
      if ($urandom_range(9) == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(value_bytes[j], 1'b1, end_on_byte && j == value_bytes.size() - 1);
    end
    // Otherwise an empty beat closes the value.
    if (!end_on_byte) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Result side ready: random stalls, plus a long hold-off on request.
  initial begin : result_ready
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_served != hold_asks) begin
        hold_served = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (gaps_on) begin
        out_tready <= ($urandom_range(99) >= 25);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compares every accepted result beat with the oldest expected flag.
  initial begin : result_check
    bit expected;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (found_expected_q.size() == 0) begin
          flag_error($sformatf("result beat with nothing expected, tdata %h", out_tdata));
        end else begin
          expected = found_expected_q.pop_front();
          if (out_tdata[0] !== expected)
            flag_error($sformatf("token_found expected %0b, got %b", expected, out_tdata[0]));
          if (out_tdata[7:1] !== 7'd0)
            flag_error($sformatf("tdata padding expected 0, got %b", out_tdata[7:1]));
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t rows [$];
    int       rand_start;
    int       phase_start;
    int       phase;

    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // After reset the token is one zero byte, which no token character equals.
    rows.push_back(b_row_exp(8'h00, 1'b0, 1'b1, 1'b0));
    rows.push_back(b_row_exp(8'h00, 1'b1, 1'b1, 1'b0));
    rows.push_back(b_row(8'hff, 1'b1, 1'b0));
    rows.push_back(b_row_exp("a", 1'b1, 1'b1, 1'b0));
    // Token "gzip": mixed case hit, empty beat inside, run too long, hit at the end.
    rows.push_back(c_row(REG_TOKEN_LENGTH, 64'd4));
    rows.push_back(c_row(REG_TOKEN_WORD0, 64'h0000_0000_7069_7a67));
    rows.push_back(b_row("G", 1'b1, 1'b0));
    rows.push_back(b_row("Z", 1'b1, 1'b0));
    rows.push_back(b_row("i", 1'b1, 1'b0));
    rows.push_back(b_row("p", 1'b1, 1'b0));
    rows.push_back(b_row(",", 1'b1, 1'b0));
    rows.push_back(b_row(8'hff, 1'b0, 1'b0));
    rows.push_back(b_row_exp(" ", 1'b1, 1'b1, 1'b1));
    rows.push_back(b_row("g", 1'b1, 1'b0));
    rows.push_back(b_row("z", 1'b1, 1'b0));
    rows.push_back(b_row("i", 1'b1, 1'b0));
    rows.push_back(b_row("p", 1'b1, 1'b0));
    rows.push_back(b_row_exp("p", 1'b1, 1'b1, 1'b0));
    rows.push_back(b_row("g", 1'b1, 1'b0));
    rows.push_back(b_row("z", 1'b1, 1'b0));
    rows.push_back(b_row("i", 1'b1, 1'b0));
    rows.push_back(b_row_exp("p", 1'b1, 1'b1, 1'b1));
    // Lengths zero and above the maximum never match.
    rows.push_back(c_row(REG_TOKEN_LENGTH, 64'd0));
    rows.push_back(b_row_exp("g", 1'b1, 1'b1, 1'b0));
    rows.push_back(c_row(REG_TOKEN_LENGTH, 64'd63));
    rows.push_back(b_row_exp("g", 1'b1, 1'b1, 1'b0));
    // An uppercase stored byte is never found.
    rows.push_back(c_row(REG_TOKEN_LENGTH, 64'd1));
    rows.push_back(c_row(REG_TOKEN_WORD0, 64'h41));
    rows.push_back(b_row_exp("a", 1'b1, 1'b1, 1'b0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        settle_idle();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_beat(rows[i].text_byte, rows[i].present, rows[i].last,
                  rows[i].typed, rows[i].typed_found);
      end
    end

    // Random phases, each with a fresh token; one without idling, one under back-pressure.
    rand_start = items_sent;
    phase = 0;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      load_token(phase);
      gaps_on = (phase != 3);
      if (phase == 4) hold_asks++;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_value();
      phase++;
    end
    gaps_on = 1'b1;

    settle_idle();
    if (fail_count == 0 && found_expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
